FILE: hw/rtl/irpwd_pkg.sv
// Shared types and constants of the IR pulse-width frame decoder.
`timescale 1ns / 1ps

package irpwd_pkg;

    localparam int LEN_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;
    localparam int DEV_ADDR_W = 3;

    localparam logic [LEN_W-1:0] PULSE_LEN_MAX = 5'd31;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_BAD_START = 2'd1;
    localparam t_status ST_BAD_BIT   = 2'd2;
    localparam t_status ST_TIMEOUT   = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_MIN      = 3'd0,
        REG_START_MAX      = 3'd1,
        REG_ZERO_MIN       = 3'd2,
        REG_ZERO_MAX       = 3'd3,
        REG_ONE_MIN        = 3'd4,
        REG_ONE_MAX        = 3'd5,
        REG_PULSE_TIMEOUT  = 3'd6,
        REG_DEVICE_ADDRESS = 3'd7
    } t_reg_index;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_LOW      = 2'd1,
        PH_GAP      = 2'd2,
        PH_WAITHIGH = 2'd3
    } t_phase;

    typedef struct packed {
        logic [LEN_W-1:0]      start_min;
        logic [LEN_W-1:0]      start_max;
        logic [LEN_W-1:0]      zero_min;
        logic [LEN_W-1:0]      zero_max;
        logic [LEN_W-1:0]      one_min;
        logic [LEN_W-1:0]      one_max;
        logic [LEN_W-1:0]      pulse_timeout;
        logic [DEV_ADDR_W-1:0] device_address;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        start_min:      5'd23,
        start_max:      5'd25,
        zero_min:       5'd4,
        zero_max:       5'd8,
        one_min:        5'd10,
        one_max:        5'd14,
        pulse_timeout:  5'd26,
        device_address: 3'd5
    };

    typedef struct packed {
        logic is_start;
        logic is_zero;
        logic is_one;
    } t_pulse_class;

endpackage

FILE: hw/rtl/irpwd_ifs.sv
// Valid/ready channel interfaces for line samples and decoded frames.
`timescale 1ns / 1ps

interface irpwd_in_if;
    logic valid;
    logic ready;
    logic ir_level;

    modport source (output valid, output ir_level, input ready);
    modport sink (input valid, input ir_level, output ready);
endinterface

interface irpwd_out_if #(
    parameter int DATA_BITS    = 8,
    parameter int ADDRESS_BITS = 3
);
    logic                      valid;
    logic                      ready;
    logic [DATA_BITS-1:0]      frame_data;
    logic [ADDRESS_BITS-1:0]   frame_address;
    irpwd_pkg::t_status        status;
    logic                      address_match;

    modport source (output valid, output frame_data, output frame_address,
                    output status, output address_match, input ready);
    modport sink (input valid, input frame_data, input frame_address,
                  input status, input address_match, output ready);
endinterface

FILE: hw/rtl/irpwd_classify.sv
// Window classifier that sorts a measured low pulse into start, zero or one.
`timescale 1ns / 1ps

module irpwd_classify (
    input  logic [irpwd_pkg::LEN_W-1:0] i_len,
    input  irpwd_pkg::t_cfg             i_cfg,
    output irpwd_pkg::t_pulse_class     o_class
);
    import irpwd_pkg::*;

    always_comb begin
        o_class.is_start = (i_len >= i_cfg.start_min) && (i_len <= i_cfg.start_max);
        o_class.is_zero  = (i_len >= i_cfg.zero_min)  && (i_len <= i_cfg.zero_max);
        o_class.is_one   = (i_len >= i_cfg.one_min)   && (i_len <= i_cfg.one_max);
    end

endmodule

FILE: hw/rtl/ir_pulse_width_frame_decoder.sv
// Top level: samples the IR line, measures low pulses and emits one word per frame.
// A sample is taken into an input register and decoded from there; a result word
// is written into the output register when the sample ending the frame is decoded.
// One sample is accepted every cycle; the input stalls only while a decoded word
// waits in the output register and the sample being decoded would produce another.
// Synchronous active-low reset returns the decoder to idle, clears the counters and
// valid flags and loads the default pulse windows, timeout and device address.
`timescale 1ns / 1ps

module ir_pulse_width_frame_decoder #(
    parameter int DATA_BITS    = 8,
    parameter int ADDRESS_BITS = 3
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [irpwd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [irpwd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    irpwd_in_if.sink                            i_sample,
    irpwd_out_if.source                         o_frame
);
    import irpwd_pkg::*;

    localparam int TOTAL_BITS = DATA_BITS + ADDRESS_BITS;
    localparam int IDX_W      = $clog2(TOTAL_BITS + 2);

    t_cfg r_cfg;

    logic r_in_valid;
    logic r_in_level;

    t_phase                r_phase, n_phase;
    logic [LEN_W-1:0]      r_len, n_len;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [TOTAL_BITS-1:0] r_bits, n_bits;

    logic                    r_out_valid;
    logic [DATA_BITS-1:0]    r_out_data;
    logic [ADDRESS_BITS-1:0] r_out_addr;
    t_status                 r_out_status;
    logic                    r_out_match;

    logic         emit;
    t_status      emit_status;
    logic         proc_fire;
    t_pulse_class pulse_class;

    logic [DATA_BITS-1:0]       res_data;
    logic [ADDRESS_BITS-1:0]    res_addr;
    logic [DEV_ADDR_W-1:0]      res_addr_ext;
    logic                       res_match;

    irpwd_classify u_classify (
        .i_len   (r_len),
        .i_cfg   (r_cfg),
        .o_class (pulse_class)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (t_reg_index'(i_cfg_index))
                REG_START_MIN:      r_cfg.start_min      <= i_cfg_data;
                REG_START_MAX:      r_cfg.start_max      <= i_cfg_data;
                REG_ZERO_MIN:       r_cfg.zero_min       <= i_cfg_data;
                REG_ZERO_MAX:       r_cfg.zero_max       <= i_cfg_data;
                REG_ONE_MIN:        r_cfg.one_min        <= i_cfg_data;
                REG_ONE_MAX:        r_cfg.one_max        <= i_cfg_data;
                REG_PULSE_TIMEOUT:  r_cfg.pulse_timeout  <= i_cfg_data;
                REG_DEVICE_ADDRESS: r_cfg.device_address <= i_cfg_data[DEV_ADDR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        logic             low;
        logic [LEN_W-1:0] len_inc;
        logic [IDX_W-1:0] pos;
        logic             bit_val;

        low     = !r_in_level;
        len_inc = (r_len < PULSE_LEN_MAX) ? r_len + 5'd1 : r_len;
        pos     = r_idx - IDX_W'(1);
        bit_val = 1'b0;

        n_phase     = r_phase;
        n_len       = r_len;
        n_idx       = r_idx;
        n_bits      = r_bits;
        emit        = 1'b0;
        emit_status = ST_OK;

        case (r_phase)
            PH_IDLE, PH_GAP: begin
                if (low) begin
                    if (r_phase == PH_IDLE) begin
                        n_idx  = '0;
                        n_bits = '0;
                    end
                    n_phase = PH_LOW;
                    n_len   = 5'd1;
                    if (5'd1 > r_cfg.pulse_timeout) begin
                        emit        = 1'b1;
                        emit_status = ST_TIMEOUT;
                        n_phase     = PH_WAITHIGH;
                    end
                end
            end
            PH_LOW: begin
                if (low) begin
                    n_len = len_inc;
                    if (len_inc > r_cfg.pulse_timeout) begin
                        emit        = 1'b1;
                        emit_status = ST_TIMEOUT;
                        n_phase     = PH_WAITHIGH;
                    end
                end else if (r_idx == '0) begin
                    if (!pulse_class.is_start) begin
                        emit        = 1'b1;
                        emit_status = ST_BAD_START;
                        n_phase     = PH_IDLE;
                    end else begin
                        n_idx   = IDX_W'(1);
                        n_bits  = '0;
                        n_phase = PH_GAP;
                    end
                end else if (!pulse_class.is_zero && !pulse_class.is_one) begin
                    emit        = 1'b1;
                    emit_status = ST_BAD_BIT;
                    n_phase     = PH_IDLE;
                end else begin
                    // The zero window wins where the two windows overlap.
                    bit_val = !pulse_class.is_zero;
                    n_bits  = r_bits | (TOTAL_BITS'(bit_val) << pos);
                    n_idx   = r_idx + IDX_W'(1);
                    if (r_idx >= IDX_W'(TOTAL_BITS)) begin
                        emit        = 1'b1;
                        emit_status = ST_OK;
                        n_phase     = PH_IDLE;
                    end else begin
                        n_phase = PH_GAP;
                    end
                end
            end
            PH_WAITHIGH: begin
                if (!low) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_comb begin
        if (emit_status == ST_OK) begin
            res_data = n_bits[DATA_BITS-1:0];
            res_addr = n_bits[TOTAL_BITS-1:DATA_BITS];
        end else begin
            res_data = '0;
            res_addr = '0;
        end
        res_addr_ext = DEV_ADDR_W'({3'b000, res_addr});
        res_match    = (emit_status == ST_OK)
                       && (res_addr_ext == r_cfg.device_address);
    end

    assign proc_fire      = r_in_valid && (!emit || !r_out_valid || o_frame.ready);
    assign i_sample.ready = !r_in_valid || proc_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_sample.ready) begin
            r_in_valid <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.valid && i_sample.ready) begin
            r_in_level <= i_sample.ir_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_len   <= '0;
            r_idx   <= '0;
            r_bits  <= '0;
        end else if (proc_fire) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_idx   <= n_idx;
            r_bits  <= n_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_frame.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire && emit) begin
            r_out_data   <= res_data;
            r_out_addr   <= res_addr;
            r_out_status <= emit_status;
            r_out_match  <= res_match;
        end
    end

    assign o_frame.valid         = r_out_valid;
    assign o_frame.frame_data    = r_out_data;
    assign o_frame.frame_address = r_out_addr;
    assign o_frame.status        = r_out_status;
    assign o_frame.address_match = r_out_match;

endmodule

FILE: tb/sv/tb_ir_pulse_width_frame_decoder.sv
// Self-checking testbench that drives IR line samples and compares every decoded frame word.
`timescale 1ns / 1ps

module tb_ir_pulse_width_frame_decoder;
    import irpwd_pkg::*;

    localparam int DATA_BITS    = 8;
    localparam int ADDRESS_BITS = 3;
    localparam int TOTAL_BITS   = DATA_BITS + ADDRESS_BITS;
    localparam int IDLE_PCT     = 22;
    localparam int DRAIN_CYCLES = 4;
    localparam int QUIET_LIMIT  = 2000;
    localparam int SAMPLE_GOAL  = 1500;
    localparam int ROUND_CAP    = 60;

    typedef struct packed {
        logic [DATA_BITS-1:0]    data;
        logic [ADDRESS_BITS-1:0] addr;
        t_status                 status;
        logic                    match;
    } t_frame_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit                    calm = 1'b0;

    irpwd_in_if smp_if ();
    irpwd_out_if #(.DATA_BITS(DATA_BITS), .ADDRESS_BITS(ADDRESS_BITS)) frm_if ();

    ir_pulse_width_frame_decoder #(
        .DATA_BITS(DATA_BITS),
        .ADDRESS_BITS(ADDRESS_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data),
        .i_sample(smp_if),
        .o_frame(frm_if)
    );

    t_cfg                  cfg_model;
    t_phase                ph_model;
    logic [LEN_W-1:0]      len_model;
    logic [3:0]            idx_model;
    logic [TOTAL_BITS-1:0] bits_model;
    t_frame_word           expected_frames[$];

    int fails;
    int samples_taken;
    int frames_seen;
    int settings_used;
    int quiet_cycles;
    int status_seen [4];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void reset_model();
        cfg_model  = CFG_RESET;
        ph_model   = PH_IDLE;
        len_model  = '0;
        idx_model  = '0;
        bits_model = '0;
    endfunction

    function automatic logic in_window(input logic [LEN_W-1:0] len,
                                       input logic [LEN_W-1:0] lo,
                                       input logic [LEN_W-1:0] hi);
        return (len >= lo) && (len <= hi);
    endfunction

    function automatic void close_frame(input t_status st);
        t_frame_word w;
        w = '0;
        w.status = st;
        if (st == ST_OK) begin
            w.data  = bits_model[DATA_BITS-1:0];
            w.addr  = bits_model[TOTAL_BITS-1:DATA_BITS];
            w.match = (w.addr == cfg_model.device_address);
        end
        expected_frames.push_back(w);
        ph_model = (st == ST_TIMEOUT) ? PH_WAITHIGH : PH_IDLE;
    endfunction

    function automatic void decode_sample(input logic level);
        logic low;
        logic taken;
        low = !level;
        taken = 1'b0;
        case (ph_model)
            PH_IDLE, PH_GAP: begin
                if (low) begin
                    if (ph_model == PH_IDLE) begin
                        idx_model  = '0;
                        bits_model = '0;
                    end
                    ph_model  = PH_LOW;
                    len_model = 5'd1;
                    if (len_model > cfg_model.pulse_timeout) close_frame(ST_TIMEOUT);
                end
            end
            PH_LOW: begin
                if (low) begin
                    if (len_model != PULSE_LEN_MAX) len_model = len_model + 5'd1;
                    if (len_model > cfg_model.pulse_timeout) close_frame(ST_TIMEOUT);
                end else if (idx_model == '0) begin
                    if (in_window(len_model, cfg_model.start_min, cfg_model.start_max)) begin
                        idx_model  = 4'd1;
                        bits_model = '0;
                        ph_model   = PH_GAP;
                    end else begin
                        close_frame(ST_BAD_START);
                    end
                end else begin
                    // The zero window wins where the two windows overlap.
                    if (in_window(len_model, cfg_model.zero_min, cfg_model.zero_max)) begin
                        taken = 1'b1;
                    end else if (in_window(len_model, cfg_model.one_min, cfg_model.one_max)) begin
                        bits_model[idx_model - 4'd1] = 1'b1;
                        taken = 1'b1;
                    end else begin
                        close_frame(ST_BAD_BIT);
                    end
                    if (taken) begin
                        idx_model = idx_model + 4'd1;
                        if (idx_model > TOTAL_BITS) close_frame(ST_OK);
                        else ph_model = PH_GAP;
                    end
                end
            end
            default: begin
                if (!low) ph_model = PH_IDLE;
            end
        endcase
    endfunction

    function automatic void check_field(input string what, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            fails++;
        end
    endfunction

    function automatic void check_frame();
        t_frame_word want;
        if (expected_frames.size() == 0) begin
            $display("%0t: unexpected word, expected none, got data %0d address %0d status %0d",
                     $time, frm_if.frame_data, frm_if.frame_address, frm_if.status);
            fails++;
        end else begin
            want = expected_frames.pop_front();
            check_field("frame_data", want.data, frm_if.frame_data);
            check_field("frame_address", 8'(want.addr), 8'(frm_if.frame_address));
            check_field("status", 8'(want.status), 8'(frm_if.status));
            check_field("address_match", 8'(want.match), 8'(frm_if.address_match));
            frames_seen++;
            status_seen[want.status]++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (frm_if.valid && frm_if.ready) check_frame();
            if (smp_if.valid && smp_if.ready) begin
                decode_sample(smp_if.ir_level);
                samples_taken++;
            end
            if ((frm_if.valid && frm_if.ready) || (smp_if.valid && smp_if.ready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d words outstanding",
                         $time, quiet_cycles, expected_frames.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        frm_if.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            frm_if.ready <= calm || ($urandom_range(99, 0) >= IDLE_PCT);
        end
    end

    task automatic send_sample(input logic level);
        @(negedge i_clk);
        while (!calm && ($urandom_range(99, 0) < IDLE_PCT)) begin
            smp_if.valid    <= 1'b0;
            smp_if.ir_level <= 1'($urandom_range(1, 0));
            @(negedge i_clk);
        end
        smp_if.valid    <= 1'b1;
        smp_if.ir_level <= level;
        do @(posedge i_clk); while (!smp_if.ready);
    endtask

    task automatic send_pulse(input int len, input int gap);
        repeat (len) send_sample(1'b0);
        repeat (gap) send_sample(1'b1);
    endtask

    task automatic drain();
        @(negedge i_clk);
        smp_if.valid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_index idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        case (idx)
            REG_START_MIN:      cfg_model.start_min = value;
            REG_START_MAX:      cfg_model.start_max = value;
            REG_ZERO_MIN:       cfg_model.zero_min = value;
            REG_ZERO_MAX:       cfg_model.zero_max = value;
            REG_ONE_MIN:        cfg_model.one_min = value;
            REG_ONE_MAX:        cfg_model.one_max = value;
            REG_PULSE_TIMEOUT:  cfg_model.pulse_timeout = value;
            REG_DEVICE_ADDRESS: cfg_model.device_address = value[DEV_ADDR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input t_cfg c);
        logic [CFG_DATA_W-DEV_ADDR_W-1:0] pad;
        pad = (CFG_DATA_W-DEV_ADDR_W)'($urandom_range(3, 0));
        drain();
        write_reg(REG_START_MIN, c.start_min);
        write_reg(REG_START_MAX, c.start_max);
        write_reg(REG_ZERO_MIN, c.zero_min);
        write_reg(REG_ZERO_MAX, c.zero_max);
        write_reg(REG_ONE_MIN, c.one_min);
        write_reg(REG_ONE_MAX, c.one_max);
        write_reg(REG_PULSE_TIMEOUT, c.pulse_timeout);
        write_reg(REG_DEVICE_ADDRESS, {pad, c.device_address});
        @(negedge i_clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic t_cfg make_cfg(input int s0, input int s1, input int z0, input int z1,
                                      input int o0, input int o1, input int tmo, input int dev);
        t_cfg c;
        c.start_min      = s0[LEN_W-1:0];
        c.start_max      = s1[LEN_W-1:0];
        c.zero_min       = z0[LEN_W-1:0];
        c.zero_max       = z1[LEN_W-1:0];
        c.one_min        = o0[LEN_W-1:0];
        c.one_max        = o1[LEN_W-1:0];
        c.pulse_timeout  = tmo[LEN_W-1:0];
        c.device_address = dev[DEV_ADDR_W-1:0];
        return c;
    endfunction

    // Short pulse windows keep frames short so words come often.
    function automatic t_cfg random_cfg();
        int z0, z1, o0, o1, s0, s1;
        z0 = $urandom_range(2, 1);
        z1 = z0 + $urandom_range(1, 0);
        if ($urandom_range(4, 0) == 0) begin
            o0 = z0;
            o1 = z1 + $urandom_range(2, 1);
        end else begin
            o0 = z1 + $urandom_range(2, 1);
            o1 = o0 + $urandom_range(1, 0);
        end
        s0 = o1 + $urandom_range(2, 0);
        s1 = s0 + $urandom_range(2, 0);
        return make_cfg(s0, s1, z0, z1, o0, o1, s1 + $urandom_range(3, 0),
                        $urandom_range(7, 0));
    endfunction

    function automatic int pick(input int lo, input int hi);
        int v;
        v = (lo > hi) ? lo : $urandom_range(hi, lo);
        return (v < 1) ? 1 : v;
    endfunction

    function automatic int bit_len(input logic v);
        return v ? pick(int'(cfg_model.one_min), int'(cfg_model.one_max))
                 : pick(int'(cfg_model.zero_min), int'(cfg_model.zero_max));
    endfunction

    function automatic int line_gap();
        return ($urandom_range(9, 0) == 0) ? $urandom_range(40, 4) : $urandom_range(3, 1);
    endfunction

    task automatic send_frame(input logic [TOTAL_BITS-1:0] word, input int start_len,
                              input int zero_len, input int one_len);
        int len;
        len = (start_len > 0) ? start_len
                              : pick(int'(cfg_model.start_min), int'(cfg_model.start_max));
        send_pulse(len, line_gap());
        for (int b = 0; b < TOTAL_BITS; b++) begin
            if (word[b]) len = (one_len > 0) ? one_len : bit_len(1'b1);
            else len = (zero_len > 0) ? zero_len : bit_len(1'b0);
            send_pulse(len, line_gap());
        end
    endtask

    task automatic send_broken_frame();
        int kept;
        kept = $urandom_range(TOTAL_BITS - 1, 0);
        send_pulse(pick(int'(cfg_model.start_min), int'(cfg_model.start_max)), line_gap());
        repeat (kept) send_pulse(bit_len(1'($urandom_range(1, 0))), line_gap());
        if ($urandom_range(1, 0) == 1)
            send_pulse($urandom_range(int'(cfg_model.pulse_timeout) + 3, 1), line_gap());
        else
            repeat (30) send_sample(1'b1);
    endtask

    task automatic test_reset_windows();
        send_frame({3'd5, 8'hA5}, 23, 4, 14);
        send_frame({3'd2, 8'h5A}, 25, 8, 10);
    endtask

    task automatic test_frame_errors();
        send_pulse(22, 3);
        send_pulse(26, 3);
        send_pulse(24, 2);
        send_pulse(9, 2);
        send_pulse(24, 2);
        send_pulse(3, 2);
        send_pulse(30, 2);
        send_pulse(24, 2);
        send_pulse(4, 1);
        send_pulse(27, 2);
        send_pulse(24, 2);
        send_pulse(15, 2);
    endtask

    task automatic test_extreme_settings();
        program_regs(make_cfg(0, 31, 1, 31, 1, 31, 30, 2));
        send_frame(11'h5C3, 30, 5, 1);
        program_regs(make_cfg(31, 0, 0, 0, 0, 0, 0, 0));
        send_pulse(3, 2);
        send_pulse(1, 1);
        program_regs(make_cfg(31, 31, 0, 0, 1, 31, 31, 7));
        send_frame(11'h7FF, 31, 1, 1);
        send_frame(11'h7FF, 36, 1, 2);
        send_pulse(30, 2);
        program_regs(make_cfg(1, 1, 1, 1, 2, 2, 1, 0));
        send_frame(11'h000, 1, 1, 1);
        send_pulse(2, 1);
    endtask

    task automatic test_random_frames();
        int round;
        int kind;
        logic [TOTAL_BITS-1:0] word;
        round = 0;
        while ((samples_taken < SAMPLE_GOAL || round < 2) && round < ROUND_CAP) begin
            program_regs(random_cfg());
            calm = (round == 1);
            repeat (4) begin
                kind = $urandom_range(99, 0);
                if (kind < 75) begin
                    word = TOTAL_BITS'($urandom_range(2047, 0));
                    if ($urandom_range(1, 0) == 1)
                        word[TOTAL_BITS-1:DATA_BITS] = cfg_model.device_address;
                    send_frame(word, 0, 0, 0);
                end else if (kind < 90) begin
                    send_broken_frame();
                end else begin
                    repeat ($urandom_range(6, 1)) send_sample(1'($urandom_range(1, 0)));
                    repeat (3) send_sample(1'b1);
                end
            end
            calm = 1'b0;
            round++;
        end
    endtask

    task automatic test_line_noise();
        program_regs(random_cfg());
        repeat (200) send_sample(1'($urandom_range(1, 0)));
        repeat (4) send_sample(1'b1);
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        smp_if.valid    <= 1'b0;
        smp_if.ir_level <= 1'b1;
        settings_used = 1;
        reset_model();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_windows();
        test_frame_errors();
        test_extreme_settings();
        test_random_frames();
        test_line_noise();

        drain();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d line samples under %0d register settings, %0d words checked.",
                 samples_taken, settings_used, frames_seen);
        $display("Word status: %0d ok, %0d bad start, %0d bad bit, %0d timeout; %0d mismatches.",
                 status_seen[ST_OK], status_seen[ST_BAD_START], status_seen[ST_BAD_BIT],
                 status_seen[ST_TIMEOUT], fails);
        if (fails == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/irpwd_pkg.sv
hw/rtl/irpwd_ifs.sv
hw/rtl/irpwd_classify.sv
hw/rtl/ir_pulse_width_frame_decoder.sv
tb/sv/tb_ir_pulse_width_frame_decoder.sv
